>>> rtl/jcmd_pkg.sv
// ----------------------------------------------------------------------------
// jcmd_pkg
// Shared types, constants and the IUPAC decode table for the Jukes-Cantor
// mean distance core.
// ----------------------------------------------------------------------------
package jcmd_pkg;

  localparam int unsigned DefMaxTaxa = 1024;
  localparam int unsigned AccW       = 48;
  localparam int unsigned WeightW    = 16;
  localparam int unsigned TaxaW      = 11;
  localparam int unsigned DistW      = 20;
  localparam int unsigned LogFracW   = 24;
  localparam logic [31:0] Ln2Q32     = 32'd2977044472;
  localparam logic [DistW-1:0] OneQ16 = DistW'(65536);
  localparam logic [DistW-1:0] OutMax = {DistW{1'b1}};

  // register addresses (word index)
  localparam logic RegNumTaxa = 1'b0;

  // one finished alignment, handed from the front to the back
  typedef struct packed {
    logic [AccW-1:0] equal_total;
    logic [AccW-1:0] differ_total;
  } jcmd_totals_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_CHECK,
    ST_DIV,
    ST_NORM,
    ST_SQ,
    ST_SQACC,
    ST_MUL3,
    ST_MULLN,
    ST_ROUND
  } jcmd_state_t;

  // decode an IUPAC character into a base mask (A=1, C=2, G=4, T=8)
  function automatic logic [3:0] base_mask(input logic [7:0] c);
    logic [3:0] m;
    m = 4'd0;
    unique case (c)
      8'h41: m = 4'd1;            // A
      8'h42: m = 4'd14;           // B
      8'h43: m = 4'd2;            // C
      8'h44: m = 4'd13;           // D
      8'h47: m = 4'd4;            // G
      8'h48: m = 4'd11;           // H
      8'h4B: m = 4'd12;           // K
      8'h4D: m = 4'd3;            // M
      8'h4E, 8'h4F, 8'h58,
      8'h3F, 8'h2D: m = 4'd15;    // N O X ? -
      8'h52: m = 4'd5;            // R
      8'h53: m = 4'd6;            // S
      8'h54, 8'h55: m = 4'd8;     // T U
      8'h56: m = 4'd7;            // V
      8'h57: m = 4'd9;            // W
      8'h59: m = 4'd10;           // Y
      default: m = 4'd0;
    endcase
    return m;
  endfunction

  // saturating accumulate at the accumulator width
  function automatic logic [AccW-1:0] sat_add(input logic [AccW-1:0] a,
                                              input logic [AccW-1:0] b);
    logic [AccW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[AccW] ? {AccW{1'b1}} : s[AccW-1:0];
  endfunction

endpackage

>>> rtl/jcmd_front.sv
// ----------------------------------------------------------------------------
// jcmd_front
// Decodes characters, pairs each taxon with the earlier taxa of its site
// through per-base counts, and accumulates weighted equal/differ totals.
// ----------------------------------------------------------------------------
module jcmd_front
  import jcmd_pkg::*;
#(
  parameter int unsigned MAX_TAXA = DefMaxTaxa
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         base_char,
  input  logic [WeightW-1:0] column_weight,
  input  logic               last_of_site,
  input  logic               last_of_alignment,
  output logic               last_pending,
  output logic               push,
  output jcmd_totals_t       push_data
);

  localparam int unsigned CntW  = $clog2(MAX_TAXA + 1);
  localparam int unsigned MsumW = $clog2(4 * MAX_TAXA + 1);
  localparam int unsigned EqW   = CntW + 2;
  localparam int unsigned CmbW  = MsumW + 3;
  localparam logic [CntW-1:0]  CntMax  = CntW'(MAX_TAXA);
  localparam logic [MsumW-1:0] MsumMax = MsumW'(4 * MAX_TAXA);

  logic [CntW-1:0]  base_seen_count [4];
  logic [MsumW-1:0] mask_bits_sum;
  logic [AccW-1:0]  equal_total;
  logic [AccW-1:0]  differ_total;

  logic [WeightW+EqW-1:0]  prod_eq;
  logic [WeightW+CmbW-1:0] prod_df;
  logic                    s2_valid;
  logic                    s2_last;

  logic [3:0]      m;
  logic [2:0]      pc;
  logic [EqW-1:0]  eq;
  logic [CmbW-1:0] combos;
  logic [CmbW-1:0] df;
  logic [MsumW:0]  msum_add;
  logic [AccW-1:0] eq_acc;
  logic [AccW-1:0] df_acc;

  // count shared and crossed base combinations against earlier taxa
  always_comb begin
    m  = base_mask(base_char);
    pc = 3'(m[0]) + 3'(m[1]) + 3'(m[2]) + 3'(m[3]);
    eq = '0;
    for (int b = 0; b < 4; b++) begin
      if (m[b]) begin
        eq = eq + EqW'(base_seen_count[b]);
      end
    end
    combos   = CmbW'(pc) * CmbW'(mask_bits_sum);
    df       = (combos > CmbW'(eq)) ? combos - CmbW'(eq) : '0;
    msum_add = (MsumW+1)'(mask_bits_sum) + (MsumW+1)'(pc);
  end

  // update per-site counts and register weighted products
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < 4; b++) begin
        base_seen_count[b] <= '0;
      end
      mask_bits_sum <= '0;
      s2_valid      <= 1'b0;
      s2_last       <= 1'b0;
    end else begin
      s2_valid <= accept;
      s2_last  <= accept & last_of_alignment;
      if (accept) begin
        if (last_of_site || last_of_alignment) begin
          for (int b = 0; b < 4; b++) begin
            base_seen_count[b] <= '0;
          end
          mask_bits_sum <= '0;
        end else begin
          for (int b = 0; b < 4; b++) begin
            if (m[b] && base_seen_count[b] < CntMax) begin
              base_seen_count[b] <= base_seen_count[b] + CntW'(1);
            end
          end
          mask_bits_sum <= (msum_add > (MsumW+1)'(MsumMax)) ? MsumMax
                                                            : msum_add[MsumW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prod_eq <= (WeightW+EqW)'(column_weight) * (WeightW+EqW)'(eq);
      prod_df <= (WeightW+CmbW)'(column_weight) * (WeightW+CmbW)'(df);
    end
  end

  // accumulate, hand totals over on the final beat
  always_comb begin
    eq_acc = sat_add(equal_total, AccW'(prod_eq));
    df_acc = sat_add(differ_total, AccW'(prod_df));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      equal_total  <= '0;
      differ_total <= '0;
    end else if (s2_valid) begin
      if (s2_last) begin
        equal_total  <= '0;
        differ_total <= '0;
      end else begin
        equal_total  <= eq_acc;
        differ_total <= df_acc;
      end
    end
  end

  assign last_pending           = s2_valid & s2_last;
  assign push                   = s2_valid & s2_last;
  assign push_data.equal_total  = eq_acc;
  assign push_data.differ_total = df_acc;

endmodule

>>> rtl/jcmd_queue.sv
// ----------------------------------------------------------------------------
// jcmd_queue
// Single-entry queue that holds one alignment's totals for the back end.
// ----------------------------------------------------------------------------
module jcmd_queue
  import jcmd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  jcmd_totals_t push_data,
  input  logic         pop,
  output logic         full,
  output jcmd_totals_t head
);

  // hold the entry until the back end takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (push) begin
      full <= 1'b1;
    end else if (pop) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      head <= push_data;
    end
  end

endmodule

>>> rtl/jcmd_back.sv
// ----------------------------------------------------------------------------
// jcmd_back
// Forms 4p/3 by restoring division, takes log2 by repeated squaring and
// scales by 3/4 ln2 into a saturated Q4.16 distance.
// ----------------------------------------------------------------------------
module jcmd_back
  import jcmd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               q_full,
  input  jcmd_totals_t       q_head,
  input  logic [TaxaW-1:0]   num_taxa,
  output logic               pop,
  output logic               done,
  output logic [DistW-1:0]   distance,
  output logic               beyond_limit,
  output logic               no_observations
);

  jcmd_state_t state, state_next;

  logic [AccW-1:0]   differ;
  logic [AccW:0]     total;
  logic [TaxaW-1:0]  n;
  logic [63:0]       num;
  logic [63:0]       den;
  logic [63:0]       r;
  logic [31:0]       q;
  logic [31:0]       y;
  logic [4:0]        k;
  logic [31:0]       z;
  logic [63:0]       zsq;
  logic [LogFracW-1:0] f;
  logic [4:0]        cnt;
  logic [31:0]       l3;
  logic [63:0]       prod;

  logic [64:0]       r2;
  logic              r_ge;
  logic [31:0]       q_new;
  logic [32:0]       t;
  logic [29:0]       l;
  logic [63:0]       rnd;
  logic [21:0]       dfull;

  // datapath helpers
  always_comb begin
    r2    = {r, 1'b0};
    r_ge  = r2 >= {1'b0, den};
    q_new = {q[30:0], r_ge};
    t     = zsq[63:31];
    l     = ((30'(k) + 30'd1) << LogFracW) - 30'(f);
    rnd   = prod + (64'd1 << 41);
    dfull = rnd[63:42];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (q_full) state_next = ST_PREP;
      ST_PREP:  state_next = ST_CHECK;
      ST_CHECK: begin
        if (total == '0 || num >= den) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt == 5'd31) begin
          state_next = (q_new == '0) ? ST_IDLE : ST_NORM;
        end
      end
      ST_NORM:  if (y[31]) state_next = ST_SQ;
      ST_SQ:    state_next = ST_SQACC;
      ST_SQACC: state_next = (cnt == 5'(LogFracW - 1)) ? ST_MUL3 : ST_SQ;
      ST_MUL3:  state_next = ST_MULLN;
      ST_MULLN: state_next = ST_ROUND;
      ST_ROUND: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs to the queue
  always_comb begin
    pop = (state == ST_IDLE) && q_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= ((state == ST_CHECK) && (total == '0 || num >= den)) ||
               ((state == ST_DIV) && cnt == 5'd31 && q_new == '0) ||
               (state == ST_ROUND);
    end
  end

  // iterate the arithmetic
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        differ <= q_head.differ_total;
        total  <= (AccW+1)'(q_head.equal_total) + (AccW+1)'(q_head.differ_total);
        n      <= (num_taxa == '0) ? TaxaW'(1) : num_taxa;
      end
      ST_PREP: begin
        num <= {14'd0, differ, 2'b00};
        den <= 64'(total) * 64'(15'(n) * 15'd3);
      end
      ST_CHECK: begin
        r   <= num;
        q   <= '0;
        cnt <= '0;
        if (total == '0) begin
          distance        <= '0;
          beyond_limit    <= 1'b0;
          no_observations <= 1'b1;
        end else if (num >= den) begin
          distance        <= OneQ16;
          beyond_limit    <= 1'b1;
          no_observations <= 1'b0;
        end
      end
      ST_DIV: begin
        r   <= r_ge ? 64'(r2 - {1'b0, den}) : r2[63:0];
        q   <= q_new;
        cnt <= cnt + 5'd1;
        y   <= 32'(33'h1_0000_0000 - 33'(q_new));
        k   <= '0;
        if (q_new == '0) begin
          distance        <= '0;
          beyond_limit    <= 1'b0;
          no_observations <= 1'b0;
        end
      end
      ST_NORM: begin
        z   <= y;
        f   <= '0;
        cnt <= '0;
        if (!y[31]) begin
          y <= {y[30:0], 1'b0};
          k <= k + 5'd1;
        end
      end
      ST_SQ: zsq <= 64'(z) * 64'(z);
      ST_SQACC: begin
        z   <= t[32] ? t[32:1] : t[31:0];
        f   <= {f[LogFracW-2:0], t[32]};
        cnt <= cnt + 5'd1;
      end
      ST_MUL3:  l3 <= 32'(l) + {1'b0, l, 1'b0};
      ST_MULLN: prod <= 64'(l3) * 64'(Ln2Q32);
      ST_ROUND: begin
        distance        <= (dfull > 22'(OutMax)) ? OutMax : dfull[DistW-1:0];
        beyond_limit    <= 1'b0;
        no_observations <= 1'b0;
      end
      default: ;
    endcase
  end

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> !(beyond_limit && no_observations))
    else $error("both flags set on one result");
  a_beyond_one: assert property (@(posedge clk) disable iff (rst)
    (done && beyond_limit) |-> distance == OneQ16)
    else $error("beyond limit without unit distance");
  a_noobs_zero: assert property (@(posedge clk) disable iff (rst)
    (done && no_observations) |-> distance == '0)
    else $error("no observations with nonzero distance");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> state == ST_PREP)
    else $error("pop did not start a computation");

endmodule

>>> rtl/jukes_cantor_mean_distance_core.sv
// ----------------------------------------------------------------------------
// jukes_cantor_mean_distance_core
// Streams alignment characters and returns the mean Jukes-Cantor distance.
// ----------------------------------------------------------------------------
// One character is taken per cycle while busy is low. The final beat of an
// alignment (last_of_alignment) raises busy while its totals reach a
// one-entry queue; the back end picks them up and shows the result after
// the 32-step divider, the normalizing shift (up to 31 steps) and 24
// squaring steps of the log unit. With no observations or at the limit the
// result comes straight after the check, and when the quotient is zero
// straight after the divider. The next alignment may stream in while that
// result is computed; its final beat holds busy high until the back end is
// free again. Each result is shown for one cycle with done high and cannot
// be stalled. num_taxa should be written only while no alignment is in
// flight.
module jukes_cantor_mean_distance_core
  import jcmd_pkg::*;
#(
  parameter int unsigned MAX_TAXA = DefMaxTaxa
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic [7:0]         base_char,
  input  logic [WeightW-1:0] column_weight,
  input  logic               last_of_site,
  input  logic               last_of_alignment,
  output logic               done,
  output logic [DistW-1:0]   distance,
  output logic               beyond_limit,
  output logic               no_observations
);

  logic [TaxaW-1:0] num_taxa;
  logic             accept;
  logic             last_pending;
  logic             push;
  jcmd_totals_t     push_data;
  logic             q_full;
  jcmd_totals_t     q_head;
  logic             pop;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      num_taxa <= TaxaW'(2);
    end else if (psel && penable && pwrite && paddr[2] == RegNumTaxa) begin
      num_taxa <= pwdata[TaxaW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegNumTaxa) ? 32'(num_taxa) : '0;

  assign busy   = q_full | last_pending;
  assign accept = start & ~busy;

  jcmd_front #(.MAX_TAXA(MAX_TAXA)) u_front (
    .clk               (clk),
    .rst               (rst),
    .accept            (accept),
    .base_char         (base_char),
    .column_weight     (column_weight),
    .last_of_site      (last_of_site),
    .last_of_alignment (last_of_alignment),
    .last_pending      (last_pending),
    .push              (push),
    .push_data         (push_data)
  );

  jcmd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (q_full),
    .head      (q_head)
  );

  jcmd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_full          (q_full),
    .q_head          (q_head),
    .num_taxa        (num_taxa),
    .pop             (pop),
    .done            (done),
    .distance        (distance),
    .beyond_limit    (beyond_limit),
    .no_observations (no_observations)
  );

endmodule
